>>> rtl/core/rtt_mean_deviation_estimator_macros.svh
// ----------------------------------------------------------------------------
// RTT estimator assertion macros
// Shared concurrent assertion shorthands for the RTT estimator core.
// ----------------------------------------------------------------------------
`ifndef RTT_MEAN_DEVIATION_ESTIMATOR_MACROS_SVH
`define RTT_MEAN_DEVIATION_ESTIMATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RMDE_ASSERT_SAME(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("rmde: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define RMDE_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("rmde: next-cycle check failed");

`endif

>>> rtl/core/rmde_pkg.sv
// ----------------------------------------------------------------------------
// RTT estimator package
// Fixed widths, item kinds and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rmde_pkg;

    // Sample counter width (saturating)
    localparam int COUNT_W = 32;

    // Configuration register index width
    localparam int CFG_INDEX_W = 2;

    // Estimate loaded at reset, truncated to the time width in use
    localparam logic [63:0] INIT_RTT_DEFAULT = 64'd1_000_000_000;

    // Item kinds carried on tuser
    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_RESET  = 1'b1
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RTT_GAIN = 2'd0,
        CFG_DEV_GAIN = 2'd1,
        CFG_INIT_RTT = 2'd2
    } cfg_index_t;

endpackage

`default_nettype wire

>>> rtl/core/rmde_ewma.sv
// ----------------------------------------------------------------------------
// RTT estimator EWMA step
// base + floor(gain * (+/-mag) / 2^F), saturated to 0 .. 2^TIME_WIDTH-1.
// ----------------------------------------------------------------------------
`default_nettype none

module rmde_ewma #(
    parameter int TIME_WIDTH     = 40,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic [TIME_WIDTH-1:0]     base,
    input  wire logic                      neg,
    input  wire logic [TIME_WIDTH-1:0]     mag,
    input  wire logic [GAIN_FRAC_BITS:0]   gain,
    output logic      [TIME_WIDTH-1:0]     result
);

    localparam int GAIN_W = GAIN_FRAC_BITS + 1;
    localparam int PROD_W = TIME_WIDTH + GAIN_W;
    localparam int SUM_W  = TIME_WIDTH + 2;

    logic [PROD_W-1:0]     prod;
    logic [TIME_WIDTH:0]   q;
    logic                  inexact;
    logic [SUM_W-1:0]      q_ceil;
    logic [SUM_W-1:0]      base_ext;
    logic [SUM_W-1:0]      sum;

    // Scaled step; the dropped fraction matters for a negative step (floor)
    assign prod     = PROD_W'(mag) * PROD_W'(gain);
    assign q        = prod[PROD_W-1:GAIN_FRAC_BITS];
    assign inexact  = |prod[GAIN_FRAC_BITS-1:0];
    assign q_ceil   = SUM_W'(q) + SUM_W'(inexact);
    assign base_ext = SUM_W'(base);
    assign sum      = base_ext + SUM_W'(q);

    // Apply with clamping at zero and at full scale
    always_comb begin
        if (neg) begin
            if (q_ceil >= base_ext) begin
                result = '0;
            end else begin
                result = TIME_WIDTH'(base_ext - q_ceil);
            end
        end else begin
            if (sum[SUM_W-1:TIME_WIDTH] != '0) begin
                result = '1;
            end else begin
                result = sum[TIME_WIDTH-1:0];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rmde_update.sv
// ----------------------------------------------------------------------------
// RTT estimator state update
// Next estimator state for one item: reset command, first sample or EWMA.
// ----------------------------------------------------------------------------
`default_nettype none

module rmde_update #(
    parameter int TIME_WIDTH     = 40,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire rmde_pkg::kind_t                 kind,
    input  wire logic [TIME_WIDTH-1:0]           sample,
    input  wire logic [GAIN_FRAC_BITS:0]         rtt_gain,
    input  wire logic [GAIN_FRAC_BITS:0]         deviation_gain,
    input  wire logic [TIME_WIDTH-1:0]           initial_rtt,
    input  wire logic [TIME_WIDTH-1:0]           est,
    input  wire logic [TIME_WIDTH-1:0]           dev,
    input  wire logic [rmde_pkg::COUNT_W-1:0]    count,
    input  wire logic [TIME_WIDTH-1:0]           last_sample,
    input  wire logic signed [TIME_WIDTH:0]      last_delta,
    output logic      [TIME_WIDTH-1:0]           est_next,
    output logic      [TIME_WIDTH-1:0]           dev_next,
    output logic      [rmde_pkg::COUNT_W-1:0]    count_next,
    output logic      [TIME_WIDTH-1:0]           last_sample_next,
    output logic signed [TIME_WIDTH:0]           last_delta_next
);

    import rmde_pkg::*;

    logic                       dneg;
    logic [TIME_WIDTH-1:0]      dmag;
    logic                       eneg;
    logic [TIME_WIDTH-1:0]      emag;
    logic signed [TIME_WIDTH:0] delta;
    logic [TIME_WIDTH-1:0]      est_ewma;
    logic [TIME_WIDTH-1:0]      dev_ewma;

    // Delta against the held estimate, and error against the deviation
    assign delta = $signed({1'b0, sample}) - $signed({1'b0, est});
    assign dneg  = sample < est;
    assign dmag  = dneg ? (est - sample) : (sample - est);
    assign eneg  = dmag < dev;
    assign emag  = eneg ? (dev - dmag) : (dmag - dev);

    rmde_ewma #(
        .TIME_WIDTH     (TIME_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_est_ewma (
        .base   (est),
        .neg    (dneg),
        .mag    (dmag),
        .gain   (rtt_gain),
        .result (est_ewma)
    );

    rmde_ewma #(
        .TIME_WIDTH     (TIME_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dev_ewma (
        .base   (dev),
        .neg    (eneg),
        .mag    (emag),
        .gain   (deviation_gain),
        .result (dev_ewma)
    );

    // Select the next state by item kind
    always_comb begin
        last_sample_next = last_sample;
        last_delta_next  = last_delta;
        if (kind == KIND_RESET) begin
            est_next   = initial_rtt;
            dev_next   = '0;
            count_next = '0;
        end else begin
            if (count == '0) begin
                // first sample seeds both estimates
                est_next = sample;
                dev_next = sample >> 1;
            end else begin
                est_next = est_ewma;
                dev_next = dev_ewma;
            end
            count_next       = (count == '1) ? count : count + COUNT_W'(1);
            last_sample_next = sample;
            last_delta_next  = delta;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rtt_mean_deviation_estimator.sv
// ----------------------------------------------------------------------------
// RTT mean-deviation estimator
// Jacobson/Karels smoothed RTT and mean deviation over a stream of samples.
// ----------------------------------------------------------------------------
// Each input beat is an RTT sample (tuser = 0) or a reset command (tuser = 1)
// and yields exactly one result beat showing the estimate, deviation, last
// sample, last delta and saturating count after that item. The block takes
// one beat per clock unless the result stalls: a beat is captured in an
// input register, and the next cycle one combinational pass (two 40x17 gain
// multiplies with clamping) updates the state registers, which double as the
// result register, so a result is presented on the clock edge after its beat
// is accepted when the result slot is free; a stalled result holds the pass
// and the input. Gains are unsigned Q1.GAIN_FRAC_BITS; the configuration port
// may be written only while the block is idle, and a new initial_rtt takes
// effect at the next reset command.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rtt_mean_deviation_estimator_macros.svh"

module rtt_mean_deviation_estimator #(
    parameter int TIME_WIDTH     = 40,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    // Configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [rmde_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [((TIME_WIDTH > GAIN_FRAC_BITS + 1) ?
                        TIME_WIDTH : GAIN_FRAC_BITS + 1)-1:0] cfg_data,

    // Input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((TIME_WIDTH + 7) / 8) * 8-1:0] s_tdata, // sample
    input  wire logic [0:0]                           s_tuser,  // kind

    // Result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // estimate, deviation, last_sample, last_delta, count (lowest bit up)
    output logic [((4 * TIME_WIDTH + 1 + rmde_pkg::COUNT_W + 7) / 8) * 8-1:0] m_tdata
);

    import rmde_pkg::*;

    localparam int GAIN_W     = GAIN_FRAC_BITS + 1;
    localparam int OUT_DATA_W = ((4 * TIME_WIDTH + 1 + COUNT_W + 7) / 8) * 8;
    localparam int RES_W      = 4 * TIME_WIDTH + 1 + COUNT_W;

    localparam logic [GAIN_W-1:0]     RTT_GAIN_RST = GAIN_W'(1) << (GAIN_FRAC_BITS - 3);
    localparam logic [GAIN_W-1:0]     DEV_GAIN_RST = GAIN_W'(1) << (GAIN_FRAC_BITS - 2);
    localparam logic [TIME_WIDTH-1:0] INIT_RTT_RST = TIME_WIDTH'(INIT_RTT_DEFAULT);

    // Configuration registers
    logic [GAIN_W-1:0]          rtt_gain_reg;
    logic [GAIN_W-1:0]          dev_gain_reg;
    logic [TIME_WIDTH-1:0]      init_rtt_reg;

    // Input register
    logic                       in_valid_reg;
    kind_t                      in_kind_reg;
    logic [TIME_WIDTH-1:0]      in_sample_reg;

    // Estimator state, also the result register
    logic                       out_valid_reg;
    logic [TIME_WIDTH-1:0]      est_reg;
    logic [TIME_WIDTH-1:0]      dev_reg;
    logic [COUNT_W-1:0]         count_reg;
    logic [TIME_WIDTH-1:0]      last_sample_reg;
    logic signed [TIME_WIDTH:0] last_delta_reg;

    logic [TIME_WIDTH-1:0]      est_next;
    logic [TIME_WIDTH-1:0]      dev_next;
    logic [COUNT_W-1:0]         count_next;
    logic [TIME_WIDTH-1:0]      last_sample_next;
    logic signed [TIME_WIDTH:0] last_delta_next;

    logic                       advance;
    logic                       s_beat;

    // Handshake: the pass runs when the result slot is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_beat    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_DATA_W'(RES_W'({count_reg, last_delta_reg, last_sample_reg,
                                            dev_reg, est_reg}));

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rtt_gain_reg <= RTT_GAIN_RST;
            dev_gain_reg <= DEV_GAIN_RST;
            init_rtt_reg <= INIT_RTT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RTT_GAIN: rtt_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_DEV_GAIN: dev_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_INIT_RTT: init_rtt_reg <= cfg_data[TIME_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_kind_reg   <= kind_t'(s_tuser[0]);
            in_sample_reg <= s_tdata[TIME_WIDTH-1:0];
        end
    end

    rmde_update #(
        .TIME_WIDTH     (TIME_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_update (
        .kind             (in_kind_reg),
        .sample           (in_sample_reg),
        .rtt_gain         (rtt_gain_reg),
        .deviation_gain   (dev_gain_reg),
        .initial_rtt      (init_rtt_reg),
        .est              (est_reg),
        .dev              (dev_reg),
        .count            (count_reg),
        .last_sample      (last_sample_reg),
        .last_delta       (last_delta_reg),
        .est_next         (est_next),
        .dev_next         (dev_next),
        .count_next       (count_next),
        .last_sample_next (last_sample_next),
        .last_delta_next  (last_delta_next)
    );

    // State and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            est_reg         <= INIT_RTT_RST;
            dev_reg         <= '0;
            count_reg       <= '0;
            last_sample_reg <= '0;
            last_delta_reg  <= '0;
        end else begin
            if (advance) begin
                out_valid_reg   <= 1'b1;
                est_reg         <= est_next;
                dev_reg         <= dev_next;
                count_reg       <= count_next;
                last_sample_reg <= last_sample_next;
                last_delta_reg  <= last_delta_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Checks
    `RMDE_ASSERT_NEXT(a_adv_shows_result, aclk, aresetn, advance, m_tvalid)
    `RMDE_ASSERT_NEXT(a_reset_clears_count, aclk, aresetn,
                      advance && (in_kind_reg == KIND_RESET), count_reg == '0)
    `RMDE_ASSERT_NEXT(a_sample_counts, aclk, aresetn,
                      advance && (in_kind_reg == KIND_SAMPLE), count_reg != '0)
    `RMDE_ASSERT_NEXT(a_first_seeds_dev, aclk, aresetn,
                      advance && (in_kind_reg == KIND_SAMPLE) && (count_reg == '0),
                      dev_reg == ($past(in_sample_reg) >> 1))
    `RMDE_ASSERT_NEXT(a_state_holds, aclk, aresetn, !advance,
                      $stable(count_reg) && $stable(est_reg))

endmodule

`default_nettype wire
